[rtl/breakpoint_envelope_generator_assert.svh]
// assertion macros for the envelope generator
`ifndef BREAKPOINT_ENVELOPE_GENERATOR_ASSERT_SVH
`define BREAKPOINT_ENVELOPE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BEG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("envelope generator: property failed");
`define BEG_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("envelope generator: forbidden condition seen");
`else
`define BEG_ASSERT(lbl, clk, rst, prop)
`define BEG_NEVER(lbl, clk, rst, cond)
`endif
`endif

[rtl/beg_pkg.sv]
`timescale 1ns / 1ps

package beg_pkg;

  localparam int BP_SLOTS    = 4;
  localparam int BP_WIDTH    = 16;
  localparam int STAGE_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STEPS   = 32 / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_RESTART     = 2'd0,
    MODE_IGNORE_BUSY = 2'd1,
    MODE_LOOP        = 2'd2,
    MODE_SINGLE      = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE         = 2'd0,
    CFG_RATE_SHIFT   = 2'd1,
    CFG_STAGE_TIMES  = 2'd2,
    CFG_STAGE_LEVELS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic scale;
    logic step;
    logic stop;
    logic prep;
    logic mul;
    logic take_l2;
    logic div_step;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic walk_pass;
    logic last_stage;
    logic span_pos;
    logic out_free;
  } status_t;

  // one 16-bit breakpoint slot out of a packed register
  function automatic logic [BP_WIDTH-1:0] bp_field(logic [CFG_DATA_W-1:0] packed_val,
                                                   logic [STAGE_W-1:0] idx);
    logic [CFG_DATA_W-1:0] shifted;
    shifted = packed_val >> {idx, 4'b0000};
    return shifted[BP_WIDTH-1:0];
  endfunction

endpackage

[rtl/breakpoint_envelope_generator.sv]
`timescale 1ns / 1ps
// channel   signals                                   direction  transfer when
// tick      tick_valid, tick_stall, trigger           in         valid && !stall
// result    result_valid, result_stall, level,        out        valid && !stall
//           finished
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in         valid && ready
//
// a stopped envelope goes straight to the output; a running one walks the stages
// (one breakpoint per cycle), then either runs out, takes the next level when the
// span is not positive, or interpolates with the 2-bit-per-cycle divider.
// rst is synchronous, active high; it clears configuration and envelope state.
// tick_stall stays high from a tick transfer until its result sits in the
// output register; a stalled result blocks only the next tick.

module breakpoint_envelope_generator #(
  parameter int STAGES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick channel
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  logic                                trigger,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [beg_pkg::BP_WIDTH-1:0] level,
  output logic                                finished,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [beg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [beg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  beg_pkg::cmd_t    cmd;
  beg_pkg::status_t status;

  // register writes never wait, so the port only holds off in reset
  assign cfg_ready = !rst;

  // sequencer: tick transfer, time scaling, stage walk, multiply, divide, output
  beg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // configuration registers, envelope state, interpolation and output register
  beg_datapath #(
    .STAGES (STAGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .trigger      (trigger),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .level        (level),
    .finished     (finished)
  );

endmodule

[rtl/beg_ctrl.sv]
`timescale 1ns / 1ps

module beg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_valid,
  output logic             tick_stall,
  input  beg_pkg::status_t status,
  output beg_pkg::cmd_t    cmd
);

  localparam int CNT_W = beg_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(beg_pkg::DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_WALK,
    S_PREP,
    S_MUL,
    S_DIV,
    S_SUM,
    S_OUT
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;

  assign tick_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (tick_valid && !tick_stall) begin
          cmd.start  = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (status.running) begin
          cmd.scale  = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WALK: begin
        if (status.walk_pass) begin
          if (status.last_stage) begin
            cmd.stop   = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (status.span_pos) begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          cmd.take_l2 = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == CNT_LAST) begin
          div_cnt_next = '0;
          state_next   = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

[rtl/beg_datapath.sv]
`timescale 1ns / 1ps
`include "breakpoint_envelope_generator_assert.svh"

module beg_datapath #(
  parameter int STAGES = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [beg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [beg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               trigger,
  input  beg_pkg::cmd_t                      cmd,
  output beg_pkg::status_t                   status,
  input  logic                               result_stall,
  output logic                               result_valid,
  output logic signed [beg_pkg::BP_WIDTH-1:0] level,
  output logic                               finished
);

  localparam int SW = beg_pkg::STAGE_W;
  localparam int BW = beg_pkg::BP_WIDTH;
  localparam int DW = beg_pkg::CFG_DATA_W;
  localparam logic [SW-1:0] LAST_STAGE = SW'(STAGES - 1);

  // configuration
  beg_pkg::mode_t     mode;
  logic signed [4:0]  rate_shift;
  logic [DW-1:0]      stage_times;
  logic [DW-1:0]      stage_levels;

  // envelope state
  logic               running;
  logic [31:0]        elapsed;
  logic [SW-1:0]      stage;
  logic signed [BW-1:0] held_level;
  logic               oneshot_done;
  logic               finished_r;

  // work registers
  logic [31:0]        t_reg;
  logic signed [BW:0] dt, dl, span;
  logic signed [BW-1:0] l1_r, l2_r;
  logic               neg;
  logic [BW:0]        rem;
  logic [31:0]        quo;

  logic               retrig;
  logic signed [4:0]  sh_cl;
  logic [3:0]         sh_amt;
  logic [45:0]        t_wide;
  logic [31:0]        t_sat;
  logic [SW-1:0]      stage_prev;
  logic [BW-1:0]      t1, t2;
  logic signed [BW-1:0] l1, l2;
  logic signed [2*BW+1:0] prod;
  logic [BW:0]        rem_nx;
  logic [31:0]        quo_nx;
  logic signed [34:0] q_signed, v_sum;
  logic signed [BW-1:0] v_sat;

  always_comb begin
    case (mode)
      beg_pkg::MODE_RESTART:     retrig = trigger;
      beg_pkg::MODE_IGNORE_BUSY: retrig = trigger && !running;
      beg_pkg::MODE_LOOP:        retrig = !running;
      default:                   retrig = trigger && !running && !oneshot_done;
    endcase
  end

  // scaled time, clamped shift, saturating at 32 bits
  always_comb begin
    if (rate_shift < -5'sd4) begin
      sh_cl = -5'sd4;
    end else if (rate_shift > 5'sd10) begin
      sh_cl = 5'sd10;
    end else begin
      sh_cl = rate_shift;
    end
    sh_amt = 4'(sh_cl + 5'sd4);
    t_wide = {14'b0, elapsed} << sh_amt;
    t_sat  = (|t_wide[45:32]) ? 32'hFFFF_FFFF : t_wide[31:0];
  end

  assign stage_prev = stage - 1'b1;
  assign t2 = beg_pkg::bp_field(stage_times, stage);
  assign l2 = signed'(beg_pkg::bp_field(stage_levels, stage));
  assign t1 = (stage != '0) ? beg_pkg::bp_field(stage_times, stage_prev) : '0;
  assign l1 = (stage != '0) ? signed'(beg_pkg::bp_field(stage_levels, stage_prev)) : '0;

  assign prod = dt * dl;

  // two restoring steps per cycle
  always_comb begin
    rem_nx = rem;
    quo_nx = quo;
    for (int i = 0; i < beg_pkg::DIV_BITS; i++) begin
      rem_nx = {rem_nx[BW-1:0], quo_nx[31]};
      quo_nx = {quo_nx[30:0], 1'b0};
      if (rem_nx >= unsigned'(span)) begin
        rem_nx    = rem_nx - unsigned'(span);
        quo_nx[0] = 1'b1;
      end
    end
  end

  always_comb begin
    q_signed = neg ? -signed'({3'b000, quo}) : signed'({3'b000, quo});
    v_sum    = 35'(l1_r) + q_signed;
    if (v_sum > 35'sd32767) begin
      v_sat = 16'sh7FFF;
    end else if (v_sum < -35'sd32768) begin
      v_sat = 16'sh8000;
    end else begin
      v_sat = v_sum[BW-1:0];
    end
  end

  assign status.running    = running;
  assign status.walk_pass  = t_reg >= {16'b0, t2};
  assign status.last_stage = (stage == LAST_STAGE);
  assign status.span_pos   = !span[BW] && (|span[BW-1:0]);
  assign status.out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= beg_pkg::MODE_RESTART;
      rate_shift   <= '0;
      stage_times  <= '0;
      stage_levels <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        beg_pkg::CFG_MODE:         mode <= beg_pkg::mode_t'(cfg_data[1:0]);
        beg_pkg::CFG_RATE_SHIFT:   rate_shift <= signed'(cfg_data[4:0]);
        beg_pkg::CFG_STAGE_TIMES:  stage_times <= cfg_data;
        beg_pkg::CFG_STAGE_LEVELS: stage_levels <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      elapsed      <= '0;
      stage        <= '0;
      held_level   <= '0;
      oneshot_done <= 1'b0;
      finished_r   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        finished_r <= 1'b0;
        if (retrig) begin
          running    <= 1'b1;
          elapsed    <= '0;
          stage      <= '0;
          held_level <= '0;
        end else if (running && elapsed != 32'hFFFF_FFFF) begin
          elapsed <= elapsed + 1'b1;
        end
      end
      if (cmd.step) begin
        stage <= stage + 1'b1;
      end
      if (cmd.stop) begin
        running      <= 1'b0;
        oneshot_done <= 1'b1;
        finished_r   <= 1'b1;
        stage        <= '0;
      end
      if (cmd.take_l2) begin
        held_level <= l2_r;
      end
      if (cmd.sum) begin
        held_level <= v_sat;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      t_reg <= t_sat;
    end
    if (cmd.prep) begin
      // walk stopped below t2, so t fits in 16 bits here
      dt   <= signed'({1'b0, t_reg[BW-1:0]}) - signed'({1'b0, t1});
      span <= signed'({1'b0, t2}) - signed'({1'b0, t1});
      dl   <= (BW+1)'(l2) - (BW+1)'(l1);
      l1_r <= l1;
      l2_r <= l2;
    end
    if (cmd.mul) begin
      neg <= prod[2*BW+1];
      quo <= prod[2*BW+1] ? 32'(-prod) : 32'(prod);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_nx;
      quo <= quo_nx;
    end
    if (cmd.emit) begin
      level    <= held_level;
      finished <= finished_r;
    end
  end

  `BEG_ASSERT(a_stage_range, clk, rst, stage <= LAST_STAGE)
  `BEG_ASSERT(a_finish_stops, clk, rst, finished_r |-> !running)
  `BEG_ASSERT(a_finish_marks_oneshot, clk, rst, finished_r |-> oneshot_done)
  `BEG_NEVER(a_emit_when_blocked, clk, rst, cmd.emit && result_valid && result_stall)

endmodule
